// File: rtl/rsp_pkg.sv
package rsp_pkg;

  // field widths
  localparam int unsigned NUM_W     = 20;
  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NOW_W     = 31;
  localparam int unsigned DIGIT_W   = 4;

  // stream packing
  localparam int unsigned S_TDATA_W = 40;  // rx_byte, now_ms, zero pad
  localparam int unsigned S_TUSER_W = 1;   // action
  localparam int unsigned M_TDATA_W = 48;  // reading_speed, report_speed
  localparam int unsigned M_TUSER_W = 3;   // reading_valid, line_discarded, report_valid

  localparam int unsigned FRACTION_DIGITS_DEF = 2;
  localparam int unsigned TIME_WIDTH_DEF      = 31;

  localparam logic [NUM_W-1:0]          NUM_RESET  = 20'd90000;
  localparam int unsigned               SPEED_MAX  = 8388607;
  localparam logic signed [SPEED_W-1:0] PEAK_RESET = -24'sd100;

  // characters
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  // parser phases
  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_INT  = 3'd2;
  localparam logic [2:0] PH_FRAC = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  typedef struct packed {
    logic latch;      // take the input beat
    logic byte_step;  // parse byte or close the line
    logic line_eval;  // evaluate the closed line, launch divide if needed
    logic end_calc;   // form window end from quotient
    logic check;      // expiry check, load result register
  } rsp_cmd_t;

  typedef struct packed {
    logic is_line;    // latched beat carries a newline
    logic need_div;   // line needs a new window end
    logic div_done;   // divider idle
    logic out_stall;  // result register full and not taken
  } rsp_stat_t;

  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

endpackage

// File: rtl/rsp_divider.sv
module rsp_divider #(
  parameter int unsigned DD_W = 27,
  parameter int unsigned DV_W = 23
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DD_W-1:0] dividend,
  input  logic [DV_W-1:0] divisor,
  output logic            done,
  output logic [DD_W-1:0] quotient,
  output logic [DV_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DD_W-1:0]  quo;
  logic [DV_W-1:0]  rem;
  logic [DV_W-1:0]  dvs;
  logic [DV_W:0]    shifted;
  logic [DV_W:0]    diff;
  logic             fits;

  // restoring step, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[DD_W-1]};
    fits    = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DD_W-2:0], fits};
      rem <= fits ? diff[DV_W-1:0] : shifted[DV_W-1:0];
    end
  end

  assign done      = ~busy;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/rsp_datapath.sv
module rsp_datapath #(
  parameter int unsigned FRACTION_DIGITS = rsp_pkg::FRACTION_DIGITS_DEF,
  parameter int unsigned TIME_WIDTH      = rsp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsp_pkg::rsp_cmd_t             cmd,
  output rsp_pkg::rsp_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [rsp_pkg::NUM_W-1:0]     cfg_data,
  input  logic [rsp_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rsp_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [rsp_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [rsp_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int unsigned SW    = rsp_pkg::SPEED_W;
  localparam int unsigned MW    = SW - 1;  // magnitude width
  localparam int unsigned TW    = (TIME_WIDTH < rsp_pkg::NOW_W) ? TIME_WIDTH : rsp_pkg::NOW_W;
  localparam int unsigned P10   = rsp_pkg::pow10(FRACTION_DIGITS);
  localparam int unsigned P10_W = $clog2(P10);
  localparam int unsigned N_W   = rsp_pkg::NUM_W + P10_W;
  localparam int unsigned END_W = ((TW > N_W) ? TW : N_W) + 2;
  localparam int unsigned FP_W  = P10_W;
  localparam int unsigned FC_W  = $clog2(FRACTION_DIGITS + 1);
  localparam int unsigned SC_W  = $clog2(P10 + 1);
  localparam int unsigned MAG_W = MW + P10_W + 1;
  localparam int unsigned IV_W  = MW + 4;
  localparam int unsigned FV_W  = FP_W + 4;

  // config
  logic [rsp_pkg::NUM_W-1:0] numerator;

  // input beat
  logic                        act_r;
  logic [rsp_pkg::BYTE_W-1:0]  byte_r;
  logic [TW-1:0]               now_r;

  // parser
  logic [2:0]       phase;
  logic             neg;
  logic [MW-1:0]    int_part;
  logic [FP_W-1:0]  frac_part;
  logic [FC_W-1:0]  frac_cnt;

  // window
  logic                   win_open;
  logic [TW-1:0]          win_start;
  logic signed [END_W-1:0] win_end;
  logic signed [SW-1:0]   peak;

  // per item
  logic signed [SW-1:0]   kph_r;
  logic                   kph_neg;
  logic                   rd_valid;
  logic signed [SW-1:0]   rd_speed;
  logic                   discarded;

  // result register
  logic                   out_valid;
  logic                   out_rd_valid;
  logic [SW-1:0]          out_rd_speed;
  logic                   out_disc;
  logic                   out_rep_valid;
  logic [SW-1:0]          out_rep_speed;

  // byte decode
  logic                        is_digit;
  logic [rsp_pkg::DIGIT_W-1:0] digit;
  logic                        is_space;
  logic                        is_nl;
  logic [IV_W-1:0]             int_v;
  logic [FV_W-1:0]             frac_v;
  logic [SC_W-1:0]             scale;
  logic [MAG_W-1:0]            mag;
  logic [MW-1:0]               mag_sat;
  logic signed [SW-1:0]        kph;

  always_comb begin
    is_digit = byte_r >= rsp_pkg::CH_0 && byte_r <= rsp_pkg::CH_9;
    digit    = byte_r[rsp_pkg::DIGIT_W-1:0];
    is_space = byte_r == rsp_pkg::CH_SPACE || byte_r == rsp_pkg::CH_TAB ||
               byte_r == rsp_pkg::CH_CR || byte_r == rsp_pkg::CH_VT ||
               byte_r == rsp_pkg::CH_FF;
    is_nl    = byte_r == rsp_pkg::CH_NL;
    int_v    = IV_W'(int_part) * IV_W'(10) + IV_W'(digit);
    frac_v   = FV_W'(frac_part) * FV_W'(10) + FV_W'(digit);
  end

  // line value: integer * 10^F + fraction scaled by the missing digits
  always_comb begin
    scale = '0;
    for (int unsigned i = 0; i <= FRACTION_DIGITS; i++) begin
      if (frac_cnt == FC_W'(i)) scale = SC_W'(rsp_pkg::pow10(FRACTION_DIGITS - i));
    end
    mag     = MAG_W'(int_part) * MAG_W'(P10) + MAG_W'(frac_part) * MAG_W'(scale);
    mag_sat = (mag > MAG_W'(rsp_pkg::SPEED_MAX)) ? MW'(rsp_pkg::SPEED_MAX) : mag[MW-1:0];
    kph     = neg ? $signed({1'b0, mag_sat}) : -$signed({1'b0, mag_sat});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      numerator <= rsp_pkg::NUM_RESET;
    end else if (cfg_valid) begin
      numerator <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= s_tuser[0];
      byte_r <= s_tdata[rsp_pkg::BYTE_W-1:0];
      now_r  <= s_tdata[rsp_pkg::BYTE_W +: TW];
    end
  end

  // parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rsp_pkg::PH_LEAD;
      neg       <= 1'b0;
      int_part  <= '0;
      frac_part <= '0;
      frac_cnt  <= '0;
    end else if (cmd.byte_step && act_r) begin
      if (is_nl) begin
        phase     <= rsp_pkg::PH_LEAD;
        neg       <= 1'b0;
        int_part  <= '0;
        frac_part <= '0;
        frac_cnt  <= '0;
      end else begin
        case (phase) inside
          rsp_pkg::PH_LEAD, rsp_pkg::PH_SIGN: begin
            if (phase == rsp_pkg::PH_LEAD && is_space) begin
              phase <= phase;
            end else if (phase == rsp_pkg::PH_LEAD &&
                         (byte_r == rsp_pkg::CH_PLUS || byte_r == rsp_pkg::CH_MINUS)) begin
              neg   <= byte_r == rsp_pkg::CH_MINUS;
              phase <= rsp_pkg::PH_SIGN;
            end else if (is_digit) begin
              int_part <= MW'(digit);
              phase    <= rsp_pkg::PH_INT;
            end else if (byte_r == rsp_pkg::CH_DOT) begin
              phase <= rsp_pkg::PH_FRAC;
            end else begin
              phase <= rsp_pkg::PH_DONE;
            end
          end
          rsp_pkg::PH_INT: begin
            if (is_digit) begin
              int_part <= (int_v > IV_W'(rsp_pkg::SPEED_MAX)) ?
                          MW'(rsp_pkg::SPEED_MAX) : int_v[MW-1:0];
            end else if (byte_r == rsp_pkg::CH_DOT) begin
              phase <= rsp_pkg::PH_FRAC;
            end else begin
              phase <= rsp_pkg::PH_DONE;
            end
          end
          rsp_pkg::PH_FRAC: begin
            if (is_digit) begin
              // extra digits are dropped, value truncates
              if (frac_cnt < FC_W'(FRACTION_DIGITS)) begin
                frac_part <= frac_v[FP_W-1:0];
                frac_cnt  <= frac_cnt + 1'b1;
              end
            end else begin
              phase <= rsp_pkg::PH_DONE;
            end
          end
          default: phase <= phase;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_step && act_r && is_nl) begin
      kph_r <= kph;
    end
  end

  // divider: numerator * 10^F over |kph|
  logic                 div_start;
  logic [N_W-1:0]       dividend;
  logic [MW-1:0]        kph_abs;
  logic                 div_done;
  logic [N_W-1:0]       quo;
  logic [MW-1:0]        rem;
  logic                 kph_zero;
  logic                 need_div;

  always_comb begin
    kph_zero  = kph_r == '0;
    need_div  = !kph_zero && (!win_open || kph_r > peak);
    div_start = cmd.line_eval && need_div;
    dividend  = N_W'(numerator) * N_W'(P10);
    kph_abs   = kph_r[SW-1] ? MW'(-kph_r) : kph_r[MW-1:0];
  end

  rsp_divider #(
    .DD_W(N_W),
    .DV_W(MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (kph_abs),
    .done     (div_done),
    .quotient (quo),
    .remainder(rem)
  );

  // window end: start + Q for positive speed; for negative speed start - Q,
  // less one where a remainder exists and the difference stays above zero
  logic signed [END_W-1:0] start_x;
  logic signed [END_W-1:0] quo_x;
  logic signed [END_W-1:0] neg_end;
  logic signed [END_W-1:0] end_val;
  logic signed [END_W-1:0] now_x;
  logic                    expire;

  always_comb begin
    start_x = $signed({{(END_W-TW){1'b0}}, win_start});
    quo_x   = $signed({{(END_W-N_W){1'b0}}, quo});
    neg_end = start_x - quo_x;
    if (!kph_neg) begin
      end_val = start_x + quo_x;
    end else if (rem != '0 && neg_end > 0) begin
      end_val = neg_end - 1;
    end else begin
      end_val = neg_end;
    end
    now_x  = $signed({{(END_W-TW){1'b0}}, now_r});
    expire = win_open && win_end < now_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_open  <= 1'b0;
      win_start <= '0;
      win_end   <= '0;
      peak      <= rsp_pkg::PEAK_RESET;
    end else begin
      if (div_start) begin
        if (!win_open) begin
          win_open  <= 1'b1;
          win_start <= now_r;
        end
        peak <= kph_r;
      end
      if (cmd.end_calc) begin
        win_end <= end_val;
      end
      if (cmd.check && expire) begin
        win_open  <= 1'b0;
        win_start <= '0;
        win_end   <= '0;
        peak      <= rsp_pkg::PEAK_RESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) kph_neg <= kph_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rd_valid  <= 1'b0;
      rd_speed  <= '0;
      discarded <= 1'b0;
    end else if (cmd.line_eval) begin
      rd_valid  <= !kph_zero;
      rd_speed  <= kph_r;
      discarded <= kph_zero;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.check) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      out_rd_valid  <= rd_valid;
      out_rd_speed  <= rd_speed;
      out_disc      <= discarded;
      out_rep_valid <= expire;
      out_rep_speed <= expire ? peak : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_rep_speed, out_rd_speed};
  assign m_tuser  = {out_rep_valid, out_disc, out_rd_valid};

  assign stat.is_line   = act_r && is_nl;
  assign stat.need_div  = need_div;
  assign stat.div_done  = div_done;
  assign stat.out_stall = out_valid && !m_tready;

endmodule

// File: rtl/rsp_ctrl.sv
module rsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  rsp_pkg::rsp_stat_t stat,
  output rsp_pkg::rsp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_LINE  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready  = 1'b1;
        cmd.latch = s_tvalid;
        if (s_tvalid) state_next = S_BYTE;
      end
      S_BYTE: begin
        cmd.byte_step = 1'b1;
        state_next    = stat.is_line ? S_LINE : S_CHECK;
      end
      S_LINE: begin
        cmd.line_eval = 1'b1;
        state_next    = stat.need_div ? S_DIV : S_CHECK;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_END;
      end
      S_END: begin
        cmd.end_calc = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.out_stall) begin
          cmd.check  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/radar_speed_peak_window.sv
// Flow: a taken input beat passes the byte step and the expiry check before its result beat is
//   shown; a newline also passes line evaluation, and one that needs a new window end then waits
//   for the divider and forms the end from the 27-bit quotient. One item at a time: the next
//   beat is taken only after the check, which waits while the result register is full and not taken.
// Reset: synchronous rst restores the numerator to 90000, closes the window and clears
//   the parser; no clearing pass.
module radar_speed_peak_window #(
  parameter int unsigned FRACTION_DIGITS = rsp_pkg::FRACTION_DIGITS_DEF,
  parameter int unsigned TIME_WIDTH      = rsp_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: window_numerator
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsp_pkg::NUM_W-1:0]     cfg_data,
  // input beats
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rsp_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte, [38:8] now_ms, [39] zero
  input  logic [rsp_pkg::S_TUSER_W-1:0] s_tuser,   // [0] action
  // result beats
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rsp_pkg::M_TDATA_W-1:0] m_tdata,   // [23:0] reading_speed, [47:24] report_speed
  output logic [rsp_pkg::M_TUSER_W-1:0] m_tuser    // [0] reading_valid, [1] line_discarded,
                                                   // [2] report_valid
);

  // Controller walks each item through byte handling, line evaluation,
  // window-end divide and the expiry check. The datapath holds the parser,
  // the window state, the divider and the result register; the result
  // register parts the two sides so the next beat is taken while a result
  // still waits.

  rsp_pkg::rsp_cmd_t  cmd;
  rsp_pkg::rsp_stat_t stat;

  // user writes the register only while idle; the block has no check for it and takes all writes
  assign cfg_ready = 1'b1;

  rsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rsp_datapath #(
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
